### hdl/cta_pkg.sv
// Shared types and constants of the clock source time accumulator.
package cta_pkg;

  localparam int CNT_W      = 64;
  localparam int SEC_W      = 64;
  localparam int NS_W       = 30;
  localparam int MULT_W     = 32;
  localparam int SHIFT_W    = 6;
  localparam int FRAC_W     = 64;
  // One second of shifted nanoseconds stays below 2^62 for shifts up to 32
  localparam int DIVISOR_W  = 62;
  // Fraction plus a 64-bit amount needs one extra bit
  localparam int DIVIDEND_W = FRAC_W + 1;

  localparam int USER_W     = 2;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 192;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [NS_W-1:0]    NS_PER_SEC  = 30'd1000000000;
  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 6'd32;

  // Sequencer counter covers both the multiply steps and the divide steps
  localparam int             SEQ_CNT_W = 7;
  localparam int             MUL_STEPS = 4;
  localparam logic [SEQ_CNT_W-1:0] MUL_LAST = SEQ_CNT_W'(MUL_STEPS);
  localparam logic [SEQ_CNT_W-1:0] DIV_LAST = SEQ_CNT_W'(DIVIDEND_W - 1);

  typedef enum logic [USER_W-1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_ADD  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAC_SHIFT   = 2'd0,
    CFG_MONO_MULT    = 2'd1,
    CFG_RAW_MULT     = 2'd2,
    CFG_COUNTER_MASK = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul_go;
    logic       mul_add;
    logic [1:0] mul_sel;
    logic       sum;
    logic       div_step;
    logic       fin;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
  } dp_status_t;

endpackage

### hdl/cta_ctrl.sv
// Sequencer of the time accumulator: load, multiply, sum, divide, writeback, output.
module cta_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  cta_pkg::dp_status_t         status,
  output cta_pkg::dp_cmd_t            cmd
);

  cta_pkg::state_t                    state, state_next;
  logic [cta_pkg::SEQ_CNT_W-1:0]      cnt, cnt_next;
  logic                               out_valid, out_valid_next;

  // State, counter and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cta_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      cta_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = cta_pkg::ST_MUL;
        end
      end
      cta_pkg::ST_MUL: begin
        if (!status.is_tick) begin
          state_next = cta_pkg::ST_SUM;
        end else begin
          cmd.mul_go  = (cnt < cta_pkg::MUL_LAST);
          cmd.mul_add = (cnt != '0);
          cmd.mul_sel = cnt[1:0];
          if (cnt == cta_pkg::MUL_LAST) begin
            state_next = cta_pkg::ST_SUM;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      cta_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        cnt_next   = '0;
        state_next = cta_pkg::ST_DIV;
      end
      cta_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == cta_pkg::DIV_LAST) begin
          state_next = cta_pkg::ST_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      cta_pkg::ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = cta_pkg::ST_DONE;
      end
      cta_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = cta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cta_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & ~m_tready);
  assign s_tready       = (state == cta_pkg::ST_IDLE);
  assign m_tvalid       = out_valid;

  a_accept_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == cta_pkg::ST_MUL))
    else $error("accepted word did not start the multiply phase");

  a_mul_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_go || cmd.mul_add) |-> status.is_tick)
    else $error("multiply step issued for a non-tick word");

  a_div_ends_in_fin: assert property (@(posedge clk) disable iff (rst)
    (state == cta_pkg::ST_DIV && cnt == cta_pkg::DIV_LAST) |=> (state == cta_pkg::ST_FIN))
    else $error("divide did not finish after its last step");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("output register overwritten before it was taken");

endmodule

### hdl/cta_dpath.sv
// Datapath of the time accumulator: config, time stores, multiplier and divider lanes.
module cta_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr,
  input  logic [cta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cta_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [cta_pkg::USER_W-1:0]        in_user,
  input  logic [cta_pkg::IN_DATA_W-1:0]     in_data,
  input  cta_pkg::dp_cmd_t                  cmd,
  output cta_pkg::dp_status_t               status,
  output logic [cta_pkg::OUT_DATA_W-1:0]    out_data
);

  // Configuration registers
  logic [cta_pkg::SHIFT_W-1:0]    frac_shift;
  logic [cta_pkg::MULT_W-1:0]     mono_mult;
  logic [cta_pkg::MULT_W-1:0]     raw_mult;
  logic [cta_pkg::CNT_W-1:0]      counter_mask;

  // Time stores
  logic [cta_pkg::SEC_W-1:0]      mono_sec, raw_sec;
  logic [cta_pkg::FRAC_W-1:0]     mono_frac, raw_frac;
  logic [cta_pkg::CNT_W-1:0]      last_count;

  // Per-word working registers
  cta_pkg::op_t                   op_q;
  logic [cta_pkg::SEC_W-1:0]      secs_q;
  logic [cta_pkg::CNT_W-1:0]      delta;
  logic [cta_pkg::FRAC_W-1:0]     mono_amt, raw_amt;
  logic [2*cta_pkg::MULT_W-1:0]   prod;
  logic [1:0]                     prod_sel;
  logic [cta_pkg::DIVISOR_W-1:0]  divisor;
  logic [cta_pkg::DIVIDEND_W-1:0] mono_q, raw_q;
  logic [cta_pkg::DIVISOR_W-1:0]  mono_rem, raw_rem;

  // Input word fields
  logic [cta_pkg::CNT_W-1:0]      in_count;
  logic [cta_pkg::SEC_W-1:0]      in_secs;
  logic [cta_pkg::NS_W-1:0]       in_nsec;

  logic [cta_pkg::SHIFT_W-1:0]    eff_shift;
  logic [cta_pkg::DIVISOR_W-1:0]  one_sec;
  logic [cta_pkg::FRAC_W-1:0]     nsec_shifted;
  logic [cta_pkg::MULT_W-1:0]     mul_a, mul_b;

  logic [cta_pkg::DIVISOR_W:0]    mono_trial, raw_trial, mono_diff, raw_diff;
  logic                           mono_ge, raw_ge;
  logic [cta_pkg::DIVISOR_W-1:0]  mono_rem_next, raw_rem_next;

  logic [cta_pkg::FRAC_W-1:0]     mono_frac_sh, raw_frac_sh;

  assign in_count = in_data[63:0];
  assign in_secs  = in_data[127:64];
  assign in_nsec  = in_data[157:128];

  // Clamp the shift and form one second of shifted nanoseconds
  assign eff_shift    = (frac_shift > cta_pkg::SHIFT_LIMIT) ? cta_pkg::SHIFT_LIMIT : frac_shift;
  assign one_sec      = cta_pkg::DIVISOR_W'(cta_pkg::NS_PER_SEC) << eff_shift;
  assign nsec_shifted = cta_pkg::FRAC_W'(in_nsec) << eff_shift;

  // Select multiplier operands: delta half by bit 0, base by bit 1
  assign mul_a = cmd.mul_sel[0] ? delta[63:32] : delta[31:0];
  assign mul_b = cmd.mul_sel[1] ? raw_mult : mono_mult;

  // One restoring divide step per lane
  always_comb begin
    mono_trial    = {mono_rem, mono_q[cta_pkg::DIVIDEND_W-1]};
    raw_trial     = {raw_rem, raw_q[cta_pkg::DIVIDEND_W-1]};
    mono_diff     = mono_trial - {1'b0, divisor};
    raw_diff      = raw_trial - {1'b0, divisor};
    mono_ge       = (mono_trial >= {1'b0, divisor});
    raw_ge        = (raw_trial >= {1'b0, divisor});
    mono_rem_next = mono_ge ? mono_diff[cta_pkg::DIVISOR_W-1:0]
                            : mono_trial[cta_pkg::DIVISOR_W-1:0];
    raw_rem_next  = raw_ge ? raw_diff[cta_pkg::DIVISOR_W-1:0]
                           : raw_trial[cta_pkg::DIVISOR_W-1:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_shift   <= '0;
      mono_mult    <= cta_pkg::MULT_W'(1);
      raw_mult     <= cta_pkg::MULT_W'(1);
      counter_mask <= '1;
    end else if (cfg_wr) begin
      case (cta_pkg::cfg_idx_t'(cfg_index))
        cta_pkg::CFG_FRAC_SHIFT:   frac_shift   <= cfg_data[cta_pkg::SHIFT_W-1:0];
        cta_pkg::CFG_MONO_MULT:    mono_mult    <= cfg_data[cta_pkg::MULT_W-1:0];
        cta_pkg::CFG_RAW_MULT:     raw_mult     <= cfg_data[cta_pkg::MULT_W-1:0];
        cta_pkg::CFG_COUNTER_MASK: counter_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Time stores and last counter reading
  always_ff @(posedge clk) begin
    if (rst) begin
      mono_sec   <= '0;
      mono_frac  <= '0;
      raw_sec    <= '0;
      raw_frac   <= '0;
      last_count <= '0;
    end else begin
      if (cmd.load && (cta_pkg::op_t'(in_user) == cta_pkg::OP_TICK)) begin
        last_count <= in_count;
      end
      // Base seconds for set and add
      if (cmd.sum) begin
        case (op_q)
          cta_pkg::OP_SET: mono_sec <= secs_q;
          cta_pkg::OP_ADD: mono_sec <= mono_sec + secs_q;
          default: ;
        endcase
      end
      // Write back quotient into seconds and remainder into fraction
      if (cmd.fin) begin
        mono_sec  <= mono_sec + mono_q[cta_pkg::SEC_W-1:0];
        raw_sec   <= raw_sec + raw_q[cta_pkg::SEC_W-1:0];
        mono_frac <= cta_pkg::FRAC_W'(mono_rem);
        raw_frac  <= cta_pkg::FRAC_W'(raw_rem);
      end
    end
  end

  // Working registers: capture, multiply-accumulate, sum and divide
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= cta_pkg::op_t'(in_user);
      secs_q   <= in_secs;
      delta    <= (in_count - last_count) & counter_mask;
      raw_amt  <= '0;
      if ((cta_pkg::op_t'(in_user) == cta_pkg::OP_SET)
          || (cta_pkg::op_t'(in_user) == cta_pkg::OP_ADD)) begin
        mono_amt <= nsec_shifted;
      end else begin
        mono_amt <= '0;
      end
    end
    if (cmd.mul_go) begin
      prod     <= mul_a * mul_b;
      prod_sel <= cmd.mul_sel;
    end
    // Add the previous partial product, high halves land 32 bits up
    if (cmd.mul_add) begin
      case (prod_sel)
        2'd0: mono_amt <= mono_amt + prod;
        2'd1: mono_amt <= mono_amt + {prod[31:0], 32'd0};
        2'd2: raw_amt  <= raw_amt + prod;
        2'd3: raw_amt  <= raw_amt + {prod[31:0], 32'd0};
        default: ;
      endcase
    end
    if (cmd.sum) begin
      if (op_q == cta_pkg::OP_SET) begin
        mono_q <= {1'b0, mono_amt};
      end else begin
        mono_q <= {1'b0, mono_frac} + {1'b0, mono_amt};
      end
      raw_q    <= {1'b0, raw_frac} + {1'b0, raw_amt};
      divisor  <= one_sec;
      mono_rem <= '0;
      raw_rem  <= '0;
    end
    // Shift dividend out and quotient bits in
    if (cmd.div_step) begin
      mono_rem <= mono_rem_next;
      raw_rem  <= raw_rem_next;
      mono_q   <= {mono_q[cta_pkg::DIVIDEND_W-2:0], mono_ge};
      raw_q    <= {raw_q[cta_pkg::DIVIDEND_W-2:0], raw_ge};
    end
  end

  assign mono_frac_sh = mono_frac >> eff_shift;
  assign raw_frac_sh  = raw_frac >> eff_shift;

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {4'd0, raw_frac_sh[cta_pkg::NS_W-1:0], raw_sec,
                   mono_frac_sh[cta_pkg::NS_W-1:0], mono_sec};
    end
  end

  assign status.is_tick = (op_q == cta_pkg::OP_TICK);

endmodule

### hdl/clocksource_time_accumulator.sv
// One word at a time: the next word is taken once the previous one is in the output register.
// Every word passes through the 65-step restoring divider; tick words also pass through the
// four-step 32x32 multiplier sequence. The output register lets the next word start while a
// result waits. Reset (synchronous, active high) clears both times, the last counter reading
// and the output valid, and restores defaults.
module clocksource_time_accumulator (
  input  logic                             clk,
  input  logic                             rst,
  // Input words
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cta_pkg::IN_DATA_W-1:0]    s_tdata,   // counter_value, seconds, nanoseconds, pad
  input  logic [cta_pkg::USER_W-1:0]       s_tuser,   // operation
  // Result words
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cta_pkg::OUT_DATA_W-1:0]   m_tdata,   // mono_seconds, mono_nanoseconds,
                                                      // raw_seconds, raw_nanoseconds, pad
  // Register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cta_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cta_pkg::dp_cmd_t    cmd;
  cta_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  cta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cta_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_user   (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata)
  );

endmodule
